// ===== rtl/core/hashed_flow_table_defines.svh =====
// Assertion macros for the flow table RTL.
`ifndef HASHED_FLOW_TABLE_DEFINES_SVH
`define HASHED_FLOW_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define HFT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flow table check failed");
// Next-cycle implication.
`define HFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flow table check failed");
`else
`define HFT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HFT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/hft_pkg.sv =====
package hft_pkg;

  localparam int DEF_NUM_FLOWS = 1024;
  localparam int SUM_W         = 32;
  localparam int OUT_SLOT_W    = 10;
  localparam int COUNT_W       = 11;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_ADDR_W    = 3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd600;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_INC   = 3'd1;
  localparam logic [2:0] OP_DEL   = 3'd2;
  localparam logic [2:0] OP_TERM  = 3'd3;
  localparam logic [2:0] OP_SWEEP = 3'd4;

  localparam logic REG_TIMEOUT = 1'b0;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        is_tcp;
    logic        dst_port_known;
    logic        src_port_known;
    logic [31:0] now_seconds;
  } in_t;

  typedef struct packed {
    logic                  status;
    logic [OUT_SLOT_W-1:0] slot;
    logic [31:0]           packet_total;
    logic [COUNT_W-1:0]    removed_count;
  } out_t;

  // Command after classification: tuple already in stored orientation.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        tcp;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        tcp;
    logic [31:0] last_seen;
    logic [31:0] packets;
    logic        ended;
  } entry_t;

endpackage

// ===== rtl/core/hft_front.sv =====
module hft_front import hft_pkg::*; #(
  parameter int NUM_FLOWS = DEF_NUM_FLOWS,
  parameter int SLOT_W    = $clog2(DEF_NUM_FLOWS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clearing,
  input  logic              in_valid,
  input  in_t               in_data,
  output logic              in_stall,
  output logic              q_push,
  output logic [SLOT_W-1:0] q_slot,
  output cmd_t              q_cmd,
  input  logic              q_full
);

  localparam bit IS_POW2 = (NUM_FLOWS & (NUM_FLOWS - 1)) == 0;
  localparam int CNT_W   = 2;
  localparam int LOG_N   = $clog2(NUM_FLOWS);
  localparam int SHIFT   = SUM_W + LOG_N;
  localparam int PROD_W  = 2 * SUM_W + 1;
  // ceil(2^SHIFT / NUM_FLOWS): exact quotient for every 32-bit sum
  localparam logic [63:0] MAGIC_W =
    ((64'd1 << SHIFT) + 64'(NUM_FLOWS) - 64'd1) / 64'(NUM_FLOWS);
  localparam logic [SUM_W:0] MAGIC = MAGIC_W[SUM_W:0];

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W-1:0]  q_r, q_nxt;
  logic [SLOT_W-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  diff;
  cmd_t              cmd_r, cmd_nxt;
  logic              done, accept, swap;

  assign done     = busy_r && (IS_POW2 || (cnt_r == '0));
  assign q_push   = done && !q_full;
  assign in_stall = clearing || (busy_r && !q_push);
  assign accept   = in_valid && !in_stall;
  assign q_cmd    = cmd_r;
  assign q_slot   = IS_POW2 ? sum_r[SLOT_W-1:0] : rem_r;
  assign swap     = !in_data.is_tcp && !in_data.dst_port_known && in_data.src_port_known;

  // Non-power-of-two table: quotient by reciprocal multiply, then remainder.
  assign prod = PROD_W'(sum_r) * PROD_W'(MAGIC);
  assign diff = sum_r - q_r * SUM_W'(NUM_FLOWS);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cmd_nxt  = cmd_r;
    if (q_push) begin
      busy_nxt = 1'b0;
    end
    if (busy_r && !IS_POW2 && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(2)) begin
        q_nxt = SUM_W'(prod >> SHIFT);
      end else begin
        rem_nxt = diff[SLOT_W-1:0];
      end
    end
    if (accept) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(2);
      sum_nxt  = in_data.src_ip + in_data.dst_ip + SUM_W'(in_data.src_port)
               + SUM_W'(in_data.dst_port) + SUM_W'(!in_data.is_tcp);
      cmd_nxt.op       = in_data.operation;
      cmd_nxt.src_ip   = swap ? in_data.dst_ip : in_data.src_ip;
      cmd_nxt.dst_ip   = swap ? in_data.src_ip : in_data.dst_ip;
      cmd_nxt.src_port = swap ? in_data.dst_port : in_data.src_port;
      cmd_nxt.dst_port = swap ? in_data.src_port : in_data.dst_port;
      cmd_nxt.tcp      = in_data.is_tcp;
      cmd_nxt.now      = in_data.now_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    sum_r <= sum_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cmd_r <= cmd_nxt;
  end

endmodule

// ===== rtl/core/hft_queue.sv =====
module hft_queue import hft_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] buf_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [PTR_W:0]   cnt_r, cnt_nxt;

  assign full     = cnt_r == (PTR_W+1)'(QUEUE_DEPTH);
  assign valid    = cnt_r != '0;
  assign pop_data = buf_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (PTR_W+1)'(1);
    if (pop && !push) cnt_nxt = cnt_r - (PTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= (wp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
      if (pop)  rp_r <= (rp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    end
    if (push) buf_r[wp_r] <= push_data;
  end

endmodule

// ===== rtl/core/hft_back.sv =====
module hft_back import hft_pkg::*; #(
  parameter int NUM_FLOWS = DEF_NUM_FLOWS,
  parameter int SLOT_W    = $clog2(DEF_NUM_FLOWS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  logic [SLOT_W-1:0] q_slot,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  input  logic [15:0]       timeout,
  output logic              clearing,
  output logic              out_valid,
  output out_t              out_data,
  input  logic              out_stall
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_SWEEP = 5'b01000,
    ST_SDONE = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [SLOT_W:0]    idx_r, idx_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt, chk_r, chk_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [31:0]        thr_r, thr_nxt;
  logic [COUNT_W-1:0] removed_r, removed_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;

  entry_t             mem [NUM_FLOWS];
  entry_t             rd_q, wr_data, fresh, upd;
  logic               rd_en, wr_en, out_ok, absent;
  logic [SLOT_W-1:0]  rd_addr, wr_addr;

  assign clearing  = state_r == ST_CLEAR;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_ok    = !out_valid_r || !out_stall;
  assign absent    = (rd_q.packets == '0) && (rd_q.src_port == '0) && (rd_q.dst_port == '0);

  always_comb begin
    fresh.src_ip    = cmd_r.src_ip;
    fresh.dst_ip    = cmd_r.dst_ip;
    fresh.src_port  = cmd_r.src_port;
    fresh.dst_port  = cmd_r.dst_port;
    fresh.tcp       = cmd_r.tcp;
    fresh.last_seen = cmd_r.now;
    fresh.packets   = 32'd1;
    fresh.ended     = 1'b0;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    chk_nxt       = chk_r;
    cmd_nxt       = cmd_r;
    thr_nxt       = thr_r;
    removed_nxt   = removed_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = q_slot;
    wr_en         = 1'b0;
    wr_addr       = slot_r;
    wr_data       = rd_q;
    upd           = rd_q;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r[SLOT_W-1:0];
        wr_data = '0;
        idx_nxt = idx_r + (SLOT_W+1)'(1);
        if (idx_r == (SLOT_W+1)'(NUM_FLOWS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          rd_en    = 1'b1;
          cmd_nxt  = q_cmd;
          slot_nxt = q_slot;
          if (q_cmd.op == OP_SWEEP) begin
            rd_addr     = '0;
            idx_nxt     = (SLOT_W+1)'(1);
            chk_nxt     = '0;
            removed_nxt = '0;
            thr_nxt     = (q_cmd.now > 32'(timeout)) ? q_cmd.now - 32'(timeout) : '0;
            state_nxt   = ST_SWEEP;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (out_ok) begin
          out_valid_nxt         = 1'b1;
          out_nxt.status        = 1'b0;
          out_nxt.slot          = OUT_SLOT_W'(slot_r);
          out_nxt.packet_total  = '0;
          out_nxt.removed_count = '0;
          unique case (cmd_r.op)
            OP_ADD: begin
              wr_en   = 1'b1;
              wr_data = fresh;
              out_nxt.packet_total = 32'd1;
            end
            OP_INC: begin
              if (absent && cmd_r.tcp) begin
                out_nxt.status       = 1'b1;
                out_nxt.packet_total = rd_q.packets;
              end else if (absent) begin
                wr_en   = 1'b1;
                wr_data = fresh;
                out_nxt.packet_total = 32'd1;
              end else begin
                if (rd_q.packets != '1) upd.packets = rd_q.packets + 32'd1;
                upd.last_seen = cmd_r.now;
                wr_en   = 1'b1;
                wr_data = upd;
                out_nxt.packet_total = upd.packets;
              end
            end
            OP_DEL: begin
              if (rd_q.packets == '0) begin
                out_nxt.status = 1'b1;
              end else begin
                upd.packets = '0;
                wr_en   = 1'b1;
                wr_data = upd;
              end
            end
            OP_TERM: begin
              upd.ended = 1'b1;
              wr_en   = 1'b1;
              wr_data = upd;
              out_nxt.packet_total = rd_q.packets;
            end
            default: begin
              out_nxt.slot = '0;
            end
          endcase
          state_nxt = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        // rd_q holds entry chk_r; write-back and next read never share an address
        if ((rd_q.packets != '0) && ((rd_q.last_seen < thr_r) || rd_q.ended)) begin
          upd.packets = '0;
          wr_en       = 1'b1;
          wr_addr     = chk_r;
          wr_data     = upd;
          removed_nxt = removed_r + COUNT_W'(1);
        end
        if (idx_r != (SLOT_W+1)'(NUM_FLOWS)) begin
          rd_en   = 1'b1;
          rd_addr = idx_r[SLOT_W-1:0];
          chk_nxt = idx_r[SLOT_W-1:0];
          idx_nxt = idx_r + (SLOT_W+1)'(1);
        end else begin
          state_nxt = ST_SDONE;
        end
      end
      ST_SDONE: begin
        if (out_ok) begin
          out_valid_nxt         = 1'b1;
          out_nxt.status        = 1'b0;
          out_nxt.slot          = '0;
          out_nxt.packet_total  = '0;
          out_nxt.removed_count = removed_r;
          state_nxt             = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r    <= slot_nxt;
    chk_r     <= chk_nxt;
    cmd_r     <= cmd_nxt;
    thr_r     <= thr_nxt;
    removed_r <= removed_nxt;
    out_r     <= out_nxt;
  end

endmodule

// ===== rtl/core/hashed_flow_table.sv =====
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_t  (operation, tuple, flags, time)
// out_      output     out_valid / out_stall  out_t (status, slot, total, removed)
// APB       input      psel/penable/pready    idle timeout register at byte 0
//
// Packet operations pass the table engine as a slot read, then a
// read-modify-write; the hash front registers the tuple sum, and for a
// table that is not a power of two also a reciprocal multiply, then a
// multiply-subtract, overlapped through the queue.
// An age-out sweep makes one table read per slot.
// After reset a clearing pass zeroes the table; in_stall stays high
// meanwhile. Register writes are taken at any time.
// A finished result waits in the output register; the queue absorbs out_stall.
`include "hashed_flow_table_defines.svh"

module hashed_flow_table import hft_pkg::*; #(
  parameter int NUM_FLOWS = DEF_NUM_FLOWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  in_t                   in_data,
  output logic                  in_stall,
  output logic                  out_valid,
  output out_t                  out_data,
  input  logic                  out_stall,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int SLOT_W = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
  localparam int Q_W    = SLOT_W + $bits(cmd_t);

  logic [15:0] timeout_r;
  logic        reg_sel;

  // byte lanes ignored; bit 2 picks the register word
  assign reg_sel = paddr[CFG_ADDR_W-1] == REG_TIMEOUT;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? 32'(timeout_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      timeout_r <= pwdata[15:0];
    end
  end

  logic              clearing;
  logic              q_push, q_full, q_pop, q_valid;
  logic [SLOT_W-1:0] f_slot, b_slot;
  cmd_t              f_cmd, b_cmd;
  logic [Q_W-1:0]    q_out;

  // Front: hash the tuple to a slot and orient it for storage.
  hft_front #(.NUM_FLOWS(NUM_FLOWS), .SLOT_W(SLOT_W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .clearing (clearing),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_push   (q_push),
    .q_slot   (f_slot),
    .q_cmd    (f_cmd),
    .q_full   (q_full)
  );

  hft_queue #(.WIDTH(Q_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_slot, f_cmd}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  assign b_slot = q_out[Q_W-1 -: SLOT_W];
  assign b_cmd  = q_out[$bits(cmd_t)-1:0];

  // Back: table memory, per-slot update and the aging sweep.
  hft_back #(.NUM_FLOWS(NUM_FLOWS), .SLOT_W(SLOT_W)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_slot    (b_slot),
    .q_cmd     (b_cmd),
    .q_pop     (q_pop),
    .timeout   (timeout_r),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  logic res_miss, res_removed, res_sweep_shape;

  assign res_miss        = out_valid && out_data.status;
  assign res_removed     = out_valid && (out_data.removed_count != '0);
  assign res_sweep_shape = (out_data.slot == '0) && (out_data.packet_total == '0);

  `HFT_ASSERT_IMPL(a_no_accept_in_clear, clk, rst_n, clearing, in_stall)
  `HFT_ASSERT_IMPL(a_queue_no_overflow, clk, rst_n, q_full && !q_pop, !q_push)
  `HFT_ASSERT_IMPL(a_miss_has_no_count, clk, rst_n, res_miss, out_data.packet_total == '0)
  `HFT_ASSERT_IMPL(a_removed_only_sweep, clk, rst_n, res_removed, res_sweep_shape)

endmodule
